// ===== hdl/ura_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ura_pkg: shared types and constants of the radix-to-ASCII converter
// Holds the value width, digit and character widths, the sequencer states
// and the function that maps a digit value to its ASCII character.
// ----------------------------------------------------------------------------
package ura_pkg;

    // Width of the converted value; the upper bits of the value port are dropped.
    localparam int VALUE_WIDTH = 64;

    localparam int BASE_W  = 6;
    localparam int DIGIT_W = 6;
    localparam int CHAR_W  = 8;

    // One digit slot per value bit covers the base-two worst case.
    localparam int DIGIT_DEPTH = VALUE_WIDTH;
    localparam int ADDR_W      = $clog2(DIGIT_DEPTH);
    localparam int STEP_W      = $clog2(VALUE_WIDTH);

    localparam logic [BASE_W-1:0] MIN_BASE = BASE_W'(2);
    localparam logic [BASE_W-1:0] MAX_BASE = BASE_W'(36);

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(8'h30);
    localparam logic [CHAR_W-1:0] ASCII_UPPER = CHAR_W'(8'h41);
    localparam logic [CHAR_W-1:0] ASCII_LOWER = CHAR_W'(8'h61);
    localparam logic [DIGIT_W-1:0] DIGIT_TEN  = DIGIT_W'(10);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_READ,
        ST_LOAD,
        ST_SEND
    } ura_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } ura_div_status_t;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(
        input logic [DIGIT_W-1:0] digit,
        input logic               upper
    );
        logic [CHAR_W-1:0] wide;
        wide = CHAR_W'(digit);
        if (digit < DIGIT_TEN) begin
            return wide + ASCII_ZERO;
        end
        else if (upper) begin
            return wide - CHAR_W'(DIGIT_TEN) + ASCII_UPPER;
        end
        else begin
            return wide - CHAR_W'(DIGIT_TEN) + ASCII_LOWER;
        end
    endfunction

endpackage
`default_nettype wire

// ===== hdl/unsigned_radix_to_ascii_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// unsigned_radix_to_ascii_core: unsigned integer to ASCII digit string
// Converts an unsigned value to its digits in base 2 to 36 and streams them
// out as ASCII characters, most significant digit first.
// ----------------------------------------------------------------------------
// A request carries a value, a base and an uppercase flag. The block takes
// one request at a time: num_stall stays high from acceptance until the last
// character of that number has been taken. Digits are produced least
// significant first by a bit-serial divider that retires one quotient bit per
// cycle, with one full division per digit. The digits are parked in a small
// digit memory and then read back in reverse order; each character passes
// through the read, load and send states of the read-back sequence and waits
// in the send state for as long as the receiver stalls it. Only the low
// VALUE_WIDTH bits of the value are converted. A zero value yields the single
// character '0', and every number's final character carries last. A request
// whose base lies outside 2 to 36 is accepted and dropped without producing
// any character.
// ----------------------------------------------------------------------------
module unsigned_radix_to_ascii_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // Number requests
    input  wire logic                        num_valid,
    output logic                             num_stall,
    input  wire logic [63:0]                 value,
    input  wire logic [ura_pkg::BASE_W-1:0]  base,
    input  wire logic                        uppercase,
    // Character stream
    output logic                             char_valid,
    input  wire logic                        char_stall,
    output logic      [ura_pkg::CHAR_W-1:0]  character,
    output logic                             last
);

    import ura_pkg::*;

    ura_state_t state_reg, state_next;

    logic [BASE_W-1:0]   base_reg, base_next;
    logic                upper_reg, upper_next;
    logic [ADDR_W-1:0]   wr_addr_reg, wr_addr_next;
    logic [ADDR_W-1:0]   rd_addr_reg, rd_addr_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    logic                last_reg, last_next;

    logic                num_accept;
    logic                char_accept;
    logic                base_ok;
    logic                quot_zero;

    // Divider interface
    logic                     div_start;
    logic [VALUE_WIDTH-1:0]   div_dividend;
    logic [BASE_W-1:0]        div_divisor;
    logic [VALUE_WIDTH-1:0]   div_quotient;
    logic [DIGIT_W-1:0]       div_remainder;
    ura_div_status_t          div_status;

    // Digit memory interface
    logic                ram_we;
    logic                ram_re;
    logic [DIGIT_W-1:0]  ram_rdata;

    assign num_accept  = num_valid && !num_stall;
    assign char_accept = char_valid && !char_stall;
    assign base_ok     = (base inside {[MIN_BASE:MAX_BASE]});
    assign quot_zero   = (div_quotient == '0);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (num_accept && base_ok)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // The last digit is reached once the quotient runs out.
                if (div_status.done && quot_zero)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (char_accept)
                begin
                    state_next = last_reg ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Outputs and control strobes
    // ------------------------------------------------------------------
    always_comb
    begin
        num_stall    = 1'b1;
        char_valid   = 1'b0;
        div_start    = 1'b0;
        div_dividend = div_quotient;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                num_stall    = 1'b0;
                div_dividend = value[VALUE_WIDTH-1:0];
                div_start    = num_accept && base_ok;
            end
            ST_DIV:
            begin
                ram_we    = div_status.done;
                div_start = div_status.done && !quot_zero;
            end
            ST_READ:
            begin
                ram_re = 1'b1;
            end
            ST_LOAD:
            begin
                char_valid = 1'b0;
            end
            ST_SEND:
            begin
                char_valid = 1'b1;
            end
            default:
            begin
                num_stall = 1'b1;
            end
        endcase
    end

    assign div_divisor = (state_reg == ST_IDLE) ? base : base_reg;

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_comb
    begin
        base_next    = base_reg;
        upper_next   = upper_reg;
        wr_addr_next = wr_addr_reg;
        rd_addr_next = rd_addr_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (num_accept)
                begin
                    base_next    = base;
                    upper_next   = uppercase;
                    wr_addr_next = '0;
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    if (quot_zero)
                    begin
                        // Read back starts at the most significant digit.
                        rd_addr_next = wr_addr_reg;
                    end
                    else
                    begin
                        wr_addr_next = wr_addr_reg + ADDR_W'(1);
                    end
                end
            end
            ST_LOAD:
            begin
                char_next = digit_to_ascii(ram_rdata, upper_reg);
                last_next = (rd_addr_reg == '0);
            end
            ST_SEND:
            begin
                if (char_accept && !last_reg)
                begin
                    rd_addr_next = rd_addr_reg - ADDR_W'(1);
                end
            end
            default:
            begin
                char_next = char_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg    <= base_next;
        upper_reg   <= upper_next;
        wr_addr_reg <= wr_addr_next;
        rd_addr_reg <= rd_addr_next;
        char_reg    <= char_next;
        last_reg    <= last_next;
    end

    assign character = char_reg;
    assign last      = last_reg;

    // ------------------------------------------------------------------
    // Shared divider and digit memory
    // ------------------------------------------------------------------
    ura_divider u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .status    (div_status)
    );

    ura_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (DIGIT_DEPTH)
    ) u_digit_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_addr_reg),
        .wdata (div_remainder),
        .re    (ram_re),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // A new division is never launched over one that is still running.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_status.busy)
        else $error("divider restarted while busy");

    // Digits are only written as a division finishes.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_DIV) && div_status.done)
        else $error("digit write outside a finished division");

    // Once the final character is taken the block is ready again.
    assert property (@(posedge clk) disable iff (!rst_n)
        (char_accept && last) |=> !num_stall)
        else $error("block not ready after the last character");

    // No new request is taken while characters are still being delivered.
    assert property (@(posedge clk) disable iff (!rst_n)
        char_valid |-> num_stall)
        else $error("request accepted during character delivery");

endmodule
`default_nettype wire

// ===== hdl/ura_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ura_ram: generic single-write, single-read memory
// One write port and one read port with a registered read data output.
// ----------------------------------------------------------------------------
module ura_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/ura_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ura_divider: bit-serial restoring divider
// Divides the value by the base one quotient bit per cycle with a single
// compare-and-subtract unit, then reports quotient and remainder.
// ----------------------------------------------------------------------------
module ura_divider (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [ura_pkg::VALUE_WIDTH-1:0]     dividend,
    input  wire logic [ura_pkg::BASE_W-1:0]          divisor,
    output logic      [ura_pkg::VALUE_WIDTH-1:0]     quotient,
    output logic      [ura_pkg::DIGIT_W-1:0]         remainder,
    output ura_pkg::ura_div_status_t                 status
);

    import ura_pkg::*;

    logic [VALUE_WIDTH-1:0] dvd_reg, dvd_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [BASE_W-1:0]      div_reg, div_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [DIGIT_W:0]       trial;
    logic [DIGIT_W:0]       diff;
    logic                   fits;

    // The partial remainder stays below the divisor, so shifting in one
    // bit never needs more than one extra bit.
    assign trial = {rem_reg, dvd_reg[VALUE_WIDTH-1]};
    assign fits  = (trial >= {1'b0, div_reg});
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            dvd_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            dvd_next  = {dvd_reg[VALUE_WIDTH-2:0], fits};
            rem_next  = fits ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(VALUE_WIDTH - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign quotient    = dvd_reg;
    assign remainder   = rem_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule
`default_nettype wire
